// ===== design/alfl_pkg.sv =====
`timescale 1ns / 1ps

package alfl_pkg;

	// field widths
	localparam int CNT_W  = 16;
	localparam int GAIN_W = 7;
	localparam int INTG_W = 9;
	localparam int CFG_W  = 9;
	localparam int LUX_W  = 31;
	localparam int DEN_W  = GAIN_W + INTG_W;

	// Q.16 coefficients and the branch products
	localparam int COEF_W = 19;
	localparam int PROD_W = COEF_W + CNT_W;
	localparam int SUM_W  = PROD_W;
	localparam int COEF_SHIFT = 16;

	localparam logic [COEF_W-1:0] K1_C0 = 19'd116281;
	localparam logic [COEF_W-1:0] K1_C1 = 19'd72476;
	localparam logic [COEF_W-1:0] K2_C0 = 19'd280396;
	localparam logic [COEF_W-1:0] K2_C1 = 19'd128110;
	localparam logic [COEF_W-1:0] K3_C0 = 19'd388366;
	localparam logic [COEF_W-1:0] K3_C1 = 19'd7766;

	// scale of 100 ms over the integration time
	localparam int SCALE_W = 7;
	localparam logic [SCALE_W-1:0] TIME_SCALE = 7'd100;

	localparam logic [LUX_W-1:0] LUX_MAX = 31'd1610612735;

	// register indexes
	localparam logic REG_GAIN = 1'b0;
	localparam logic REG_INTG = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RST = 7'd1;
	localparam logic [INTG_W-1:0] INTG_RST = 9'd100;

	typedef enum logic [2:0] {
		BAND_ZERO = 3'd0,
		BAND_LOW  = 3'd1,
		BAND_MID  = 3'd2,
		BAND_HIGH = 3'd3,
		BAND_DARK = 3'd4
	} band_t;

	typedef struct packed {
		band_t band;
		logic  nz;
	} item_tag_t;

	typedef struct packed {
		logic             sat;
		band_t            band;
		logic [DEN_W-1:0] rem;
		logic [LUX_W-1:0] word;
	} div_data_t;

endpackage

// ===== design/alfl_front.sv =====
`timescale 1ns / 1ps

module alfl_front #(
	parameter int FRAC_BITS = 12,
	parameter int NW        = 26 + FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_take,
	input  logic [alfl_pkg::CNT_W-1:0]    c0,
	input  logic [alfl_pkg::CNT_W-1:0]    c1,
	output logic                          out_v,
	output alfl_pkg::item_tag_t           out_tag,
	output logic [NW-1:0]                 out_n
);

	localparam int TOT_W = alfl_pkg::CNT_W + 1;
	localparam int CMP_W = TOT_W + 7;
	localparam int SC_W  = alfl_pkg::SUM_W + alfl_pkg::SCALE_W;

	// stage 1: ratio band by cross-multiplication
	logic [TOT_W-1:0] tot;
	logic [CMP_W-1:0] c1x100, tot45, tot64, tot85;
	alfl_pkg::band_t  band_c;

	always_comb begin
		tot    = TOT_W'(c0) + TOT_W'(c1);
		c1x100 = CMP_W'(c1) * CMP_W'(100);
		tot45  = CMP_W'(tot) * CMP_W'(45);
		tot64  = CMP_W'(tot) * CMP_W'(64);
		tot85  = CMP_W'(tot) * CMP_W'(85);
		if (tot == '0) begin
			band_c = alfl_pkg::BAND_ZERO;
		end else if (c1x100 < tot45) begin
			band_c = alfl_pkg::BAND_LOW;
		end else if (c1x100 < tot64) begin
			band_c = alfl_pkg::BAND_MID;
		end else if (c1x100 < tot85) begin
			band_c = alfl_pkg::BAND_HIGH;
		end else begin
			band_c = alfl_pkg::BAND_DARK;
		end
	end

	logic                         v_s1, v_s2, v_s3, v_s4;
	logic [alfl_pkg::CNT_W-1:0]   c0_s1, c1_s1;
	alfl_pkg::band_t              band_s1, band_s2, band_s3;

	// stage 2: coefficient products
	logic [alfl_pkg::COEF_W-1:0]  k0, k1;
	logic                         neg;
	logic [alfl_pkg::PROD_W-1:0]  p0_s2, p1_s2;
	logic                         neg_s2;

	always_comb begin
		case (band_s1)
			alfl_pkg::BAND_LOW: begin
				k0 = alfl_pkg::K1_C0; k1 = alfl_pkg::K1_C1; neg = 1'b0;
			end
			alfl_pkg::BAND_MID: begin
				k0 = alfl_pkg::K2_C0; k1 = alfl_pkg::K2_C1; neg = 1'b1;
			end
			alfl_pkg::BAND_HIGH: begin
				k0 = alfl_pkg::K3_C0; k1 = alfl_pkg::K3_C1; neg = 1'b1;
			end
			default: begin
				k0 = '0; k1 = '0; neg = 1'b0;
			end
		endcase
	end

	// stage 3: branch sum, clamp negative to zero
	logic [alfl_pkg::SUM_W:0]     diff;
	logic [alfl_pkg::SUM_W-1:0]   sum_s3;

	always_comb begin
		if (neg_s2) begin
			diff = {1'b0, p0_s2} - {1'b0, p1_s2};
		end else begin
			diff = {1'b0, p0_s2} + {1'b0, p1_s2};
		end
	end

	// stage 4: apply 100 ms scale and fraction bits
	logic [SC_W-1:0] scaled;
	assign scaled = SC_W'(sum_s3) * SC_W'(alfl_pkg::TIME_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_take;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c0_s1        <= c0;
			c1_s1        <= c1;
			band_s1      <= band_c;
			p0_s2        <= alfl_pkg::PROD_W'(k0) * alfl_pkg::PROD_W'(c0_s1);
			p1_s2        <= alfl_pkg::PROD_W'(k1) * alfl_pkg::PROD_W'(c1_s1);
			neg_s2       <= neg;
			band_s2      <= band_s1;
			sum_s3       <= diff[alfl_pkg::SUM_W] ? '0 : diff[alfl_pkg::SUM_W-1:0];
			band_s3      <= band_s2;
			out_n        <= scaled[SC_W-1 -: NW];
			out_tag.nz   <= (sum_s3 != '0);
			out_tag.band <= band_s3;
		end
	end

	assign out_v = v_s4;

endmodule

// ===== design/alfl_div_stage.sv =====
`timescale 1ns / 1ps

module alfl_div_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [alfl_pkg::DEN_W-1:0]  den,
	input  logic                        in_v,
	input  alfl_pkg::div_data_t         in_d,
	output logic                        out_v,
	output alfl_pkg::div_data_t         out_d
);

	localparam int W = alfl_pkg::LUX_W;

	logic [alfl_pkg::DEN_W:0] shifted, trial;
	logic                     ge;
	alfl_pkg::div_data_t      nxt;

	// one restoring step: bring down the next dividend bit, try subtract;
	// a zero divisor yields a zero quotient, saturation covers nonzero sums
	always_comb begin
		shifted  = {in_d.rem, in_d.word[W-1]};
		trial    = shifted - {1'b0, den};
		ge       = (den != '0) && (shifted >= {1'b0, den});
		nxt      = in_d;
		nxt.rem  = ge ? trial[alfl_pkg::DEN_W-1:0] : shifted[alfl_pkg::DEN_W-1:0];
		nxt.word = {in_d.word[W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (adv) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_d <= nxt;
		end
	end

endmodule

// ===== design/ambient_light_lux_from_two_channels.sv =====
`timescale 1ns / 1ps

// Two-channel ambient light to lux converter.
// Input channel: one beat carries a visible-plus-IR count and an IR count;
// a beat is taken at a rising edge with in_valid high and in_stall low.
// Output channel: one beat per input beat, in order, carrying lux_q12
// (unsigned, FRAC_BITS fraction bits, truncated, saturated) and the ratio
// band; taken at an edge with out_valid high and out_stall low.
// Throughput: one beat per cycle while the output is not stalled. The path
// runs through four front stages (band, products, sum, scale),
// one saturation stage, a 31-stage divider that resolves one quotient bit
// per stage, and the output register.
// Stall: the whole pipeline holds while a result waits on a stalled output;
// in_stall is raised in exactly those cycles, so nothing is lost or repeated.
// Reset: clears every valid bit; the gain register returns to 1 and
// integration_ms to 100.
// Configuration: wr_en writes register wr_index (0 gain, 1 integration time)
// from wr_data; write only while the pipeline is empty.

module ambient_light_lux_from_two_channels #(
	parameter int FRAC_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [alfl_pkg::CNT_W-1:0]    count_visible_ir,
	input  logic [alfl_pkg::CNT_W-1:0]    count_ir,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [alfl_pkg::LUX_W-1:0]    lux_q12,
	output logic [2:0]                    ratio_band,
	input  logic                          wr_en,
	input  logic                          wr_index,
	input  logic [alfl_pkg::CFG_W-1:0]    wr_data
);

	localparam int QW    = alfl_pkg::LUX_W;
	localparam int DW    = alfl_pkg::DEN_W;
	// scaled dividend: sum * 100 >> (16 - FRAC_BITS)
	localparam int NW    = alfl_pkg::SUM_W + alfl_pkg::SCALE_W
		- (alfl_pkg::COEF_SHIFT - FRAC_BITS);
	localparam int HI_W  = NW - QW;
	localparam int DSH_W = DW + QW;

	// configuration registers and the combined divisor
	logic [alfl_pkg::GAIN_W-1:0] gain_q;
	logic [alfl_pkg::INTG_W-1:0] integ_q;
	logic [DW-1:0]               den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= alfl_pkg::GAIN_RST;
			integ_q <= alfl_pkg::INTG_RST;
			den_q   <= DW'(alfl_pkg::GAIN_RST) * DW'(alfl_pkg::INTG_RST);
		end else begin
			if (wr_en && wr_index == alfl_pkg::REG_GAIN) begin
				gain_q <= wr_data[alfl_pkg::GAIN_W-1:0];
			end
			if (wr_en && wr_index == alfl_pkg::REG_INTG) begin
				integ_q <= wr_data[alfl_pkg::INTG_W-1:0];
			end
			// settles in the cycle after a write reaches gain_q or integ_q
			den_q <= DW'(gain_q) * DW'(integ_q);
		end
	end

	// advance the whole pipeline unless a finished result is stuck
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// front stages: band, products, sum, scale
	logic                 f_v;
	alfl_pkg::item_tag_t  f_tag;
	logic [NW-1:0]        f_n;

	alfl_front #(
		.FRAC_BITS (FRAC_BITS),
		.NW        (NW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_take (in_valid),
		.c0      (count_visible_ir),
		.c1      (count_ir),
		.out_v   (f_v),
		.out_tag (f_tag),
		.out_n   (f_n)
	);

	// saturation stage: quotient overflows 31 bits iff n >= den << 31.
	// A zero divisor saturates any nonzero sum.
	logic [DSH_W-1:0]     n_ext, den_sh;
	alfl_pkg::div_data_t  init_d;

	always_comb begin
		n_ext       = {{(DSH_W-NW){1'b0}}, f_n};
		den_sh      = {den_q, {QW{1'b0}}};
		init_d.sat  = f_tag.nz && ((den_q == '0) || (n_ext >= den_sh));
		init_d.band = f_tag.band;
		init_d.rem  = {{(DW-HI_W){1'b0}}, f_n[NW-1:QW]};
		init_d.word = f_n[QW-1:0];
	end

	logic                 div_v [0:QW];
	alfl_pkg::div_data_t  div_d [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v[0] <= 1'b0;
		end else if (adv) begin
			div_v[0] <= f_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_d[0] <= init_d;
		end
	end

	// divider: one quotient bit per stage
	genvar gi;
	generate
		for (gi = 0; gi < QW; gi++) begin : g_div
			alfl_div_stage u_stage (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (adv),
				.den    (den_q),
				.in_v   (div_v[gi]),
				.in_d   (div_d[gi]),
				.out_v  (div_v[gi+1]),
				.out_d  (div_d[gi+1])
			);
		end
	endgenerate

	// output register: clamp the quotient to the top of the range
	logic [QW-1:0]   quot;
	logic [QW-1:0]   lux_c;
	logic            out_valid_q;
	logic [QW-1:0]   lux_q;
	alfl_pkg::band_t band_q;

	always_comb begin
		quot = div_d[QW].word;
		if (div_d[QW].sat || quot > alfl_pkg::LUX_MAX) begin
			lux_c = alfl_pkg::LUX_MAX;
		end else begin
			lux_c = quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lux_q  <= lux_c;
			band_q <= div_d[QW].band;
		end
	end

	assign out_valid  = out_valid_q;
	assign lux_q12    = lux_q;
	assign ratio_band = band_q;

	// dark or empty readings never produce light
	a_dark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (band_q == alfl_pkg::BAND_ZERO || band_q == alfl_pkg::BAND_DARK)
		|-> lux_q == '0)
		else $error("nonzero lux for an empty or dark reading");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> lux_q <= alfl_pkg::LUX_MAX)
		else $error("lux beyond saturation limit");

	// an unsaturated beat enters the divider with a partial remainder below den
	a_rem_init: assert property (@(posedge clk) disable iff (!arst_n)
		div_v[0] && !div_d[0].sat && den_q != '0 |-> div_d[0].rem < den_q)
		else $error("divider entry remainder not below divisor");

	// a held pipeline keeps its divider entry beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(div_v[0]) && $stable(div_d[0]))
		else $error("divider entry changed while held");

endmodule
